@@ hdl/bmls_pkg.sv @@
`default_nettype none

package bmls_pkg;

    // frame geometry and lightmap size
    localparam int WIDTH      = 320;
    localparam int OUT_ROWS   = 198;
    localparam int LIGHT_BITS = 9;

    // derived widths
    localparam int LM_AW  = 2 * LIGHT_BITS;
    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(OUT_ROWS + 2);
    localparam int ADDR_W = 18;
    localparam int CFG_W  = 10;
    localparam int BIAS_W = 9;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PIPE_LAT   = 3;

    // register indexes
    localparam logic [1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [1:0] CFG_X_BIAS  = 2'd2;
    localparam logic [1:0] CFG_Y_BIAS  = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0]  light_x;
        logic [CFG_W-1:0]  light_y;
        logic [BIAS_W-1:0] x_bias;
        logic [BIAS_W-1:0] y_bias;
    } t_cfg;

    // one request after the line buffers
    typedef struct packed {
        logic              valid;
        logic              load;
        logic              emit;
        logic              last;
        logic [ADDR_W-1:0] laddr;
        logic [7:0]        lvalue;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [7:0]        below;
        logic [7:0]        right;
        logic [7:0]        left;
        logic [7:0]        above;
    } t_tap;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] shade;
    } t_res;

endpackage

`default_nettype wire

@@ hdl/bmls_in_if.sv @@
`default_nettype none

interface bmls_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [bmls_pkg::ADDR_W-1:0] light_addr;
    logic [7:0]                  light_value;
    logic [7:0]                  height;

    modport source (output valid, output mode, output light_addr, output light_value,
                    output height, input ready);
    modport sink (input valid, input mode, input light_addr, input light_value,
                  input height, output ready);
endinterface

`default_nettype wire

@@ hdl/bmls_out_if.sv @@
`default_nettype none

interface bmls_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] shade;
    logic       last;

    modport source (output valid, output shade, output last, input ready);
    modport sink (input valid, input shade, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/bmls_window.sv @@
`default_nettype none

module bmls_window (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_acc,
    input  wire logic                        i_mode,
    input  wire logic [bmls_pkg::ADDR_W-1:0] i_light_addr,
    input  wire logic [7:0]                  i_light_value,
    input  wire logic [7:0]                  i_height,
    output bmls_pkg::t_tap                   o_tap
);

    localparam int DA = bmls_pkg::WIDTH - 1;
    localparam int DB = bmls_pkg::WIDTH;
    localparam int AA = $clog2(DA);
    localparam int AB = $clog2(DB);
    localparam int CW = bmls_pkg::COL_W;
    localparam int RW = bmls_pkg::ROW_W;

    logic pix_acc;
    assign pix_acc = i_acc && i_mode;

    // line buffers: a delays by width-1 pixels, b by a full row after that
    logic [7:0]    r_mem_a [DA];
    logic [7:0]    r_mem_b [DB];
    logic [AA-1:0] r_ptr_a;
    logic [AB-1:0] r_ptr_b;
    logic [7:0]    r_rd_a;
    logic [7:0]    r_rd_b;
    logic [7:0]    r_mid;
    logic [7:0]    r_left;
    logic [7:0]    r_below;

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_mem_a[r_ptr_a] <= i_height;
            r_rd_a           <= r_mem_a[r_ptr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_mem_b[r_ptr_b] <= r_rd_a;
            r_rd_b           <= r_mem_b[r_ptr_b];
        end
    end

    // short taps around the right/left neighbors
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_mid   <= r_rd_a;
            r_left  <= r_mid;
            r_below <= i_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_a <= '0;
            r_ptr_b <= '0;
        end else if (pix_acc) begin
            r_ptr_a <= (r_ptr_a == AA'(DA - 1)) ? '0 : r_ptr_a + AA'(1);
            r_ptr_b <= (r_ptr_b == AB'(DB - 1)) ? '0 : r_ptr_b + AB'(1);
        end
    end

    // raster position
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col == CW'(bmls_pkg::WIDTH - 1)) begin
            n_col = '0;
            n_row = (r_row == RW'(bmls_pkg::OUT_ROWS + 1)) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // request stage alongside the buffer read data
    logic                        r_valid;
    logic                        r_load;
    logic                        r_emit;
    logic                        r_last;
    logic [bmls_pkg::ADDR_W-1:0] r_laddr;
    logic [7:0]                  r_lvalue;
    logic [CW-1:0]               r_tcol;
    logic [RW-1:0]               r_trow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_load   <= !i_mode;
            r_emit   <= r_row >= RW'(2);
            r_last   <= (r_row == RW'(bmls_pkg::OUT_ROWS + 1)) &&
                        (r_col == CW'(bmls_pkg::WIDTH - 1));
            r_laddr  <= i_light_addr;
            r_lvalue <= i_light_value;
            r_tcol   <= r_col;
            r_trow   <= r_row;
        end
    end

    assign o_tap.valid  = r_valid;
    assign o_tap.load   = r_load;
    assign o_tap.emit   = r_emit;
    assign o_tap.last   = r_last;
    assign o_tap.laddr  = r_laddr;
    assign o_tap.lvalue = r_lvalue;
    assign o_tap.col    = r_tcol;
    assign o_tap.row    = r_trow;
    assign o_tap.below  = r_below;
    assign o_tap.right  = r_rd_a;
    assign o_tap.left   = r_left;
    assign o_tap.above  = r_rd_b;

endmodule

`default_nettype wire

@@ hdl/bmls_lookup.sv @@
`default_nettype none

module bmls_lookup (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  bmls_pkg::t_cfg i_cfg,
    input  bmls_pkg::t_tap i_tap,
    output bmls_pkg::t_res o_res
);

    localparam int AW = bmls_pkg::LM_AW;
    localparam int LB = bmls_pkg::LIGHT_BITS;

    // gradients, wrapped to 8 bits and taken as signed
    logic signed [7:0] ddx;
    logic signed [7:0] ddy;
    logic [AW-1:0]     dx;
    logic [AW-1:0]     dy;
    logic [AW-1:0]     idx;
    logic [AW-1:0]     waddr;

    assign ddx = i_tap.right - i_tap.left;
    assign ddy = i_tap.below - i_tap.above;

    assign dx = AW'(ddx) - AW'($signed(i_cfg.light_x)) + AW'(i_cfg.x_bias)
              + AW'(i_tap.col);
    assign dy = AW'(ddy) - AW'($signed(i_cfg.light_y)) + AW'(i_cfg.y_bias)
              + AW'(i_tap.row) - AW'(1);

    // dy * 2^LB + dx, wrapped to the store size
    assign idx   = {dy[LB-1:0] + dx[AW-1:LB], dx[LB-1:0]};
    assign waddr = AW'(i_tap.laddr);

    // address stage
    logic          r_valid;
    logic          r_write;
    logic          r_last;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tap.valid && (i_tap.load || i_tap.emit);
        end
    end

    always_ff @(posedge i_clk) begin
        r_write <= i_tap.load;
        r_last  <= i_tap.last;
        r_addr  <= i_tap.load ? waddr : idx;
        r_wdata <= i_tap.lvalue;
    end

    // lightmap: one port, loads and lookups in arrival order
    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;
    logic       r_out_valid;
    logic       r_out_last;

    always_ff @(posedge i_clk) begin
        if (r_valid && r_write) begin
            r_mem[r_addr] <= r_wdata;
        end
        if (r_valid && !r_write) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid && !r_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid && !r_write) begin
            r_out_last <= r_last;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.last  = r_out_last;
    assign o_res.shade = r_rdata;

endmodule

`default_nettype wire

@@ hdl/bmls_out_fifo.sv @@
`default_nettype none

module bmls_out_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  bmls_pkg::t_res i_res,
    output logic           o_space,
    bmls_out_if.source     o_out
);

    localparam int DEPTH = bmls_pkg::FIFO_DEPTH;
    localparam int AW    = bmls_pkg::FIFO_AW;
    localparam int CNT_W = AW + 1;

    logic [8:0]       r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign push = i_res.valid;
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= {i_res.last, i_res.shade};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // room for this request and every one still in the pipeline
    assign o_space = r_count <= CNT_W'(DEPTH - bmls_pkg::PIPE_LAT - 1);

    assign o_out.valid = r_count != '0;
    assign o_out.last  = r_mem[r_rd][8];
    assign o_out.shade = r_mem[r_rd][7:0];

endmodule

`default_nettype wire

@@ hdl/bump_map_light_shader.sv @@
`default_nettype none

// Bump-mapped shading by lightmap lookup. Mode-1 requests carry a height map in
// raster order, WIDTH pixels a row and OUT_ROWS+2 rows a frame; every pixel from
// the third row on yields one shade read from the lightmap at the point set by
// its gradient, its position, the bias and the light registers, with last set on
// the final shade of a frame. Mode-0 requests write one lightmap byte and yield
// nothing; lookups see every load that came before them. A request of either
// kind is taken every clock while the input is ready; its shade reaches the
// output queue through the window and lookup registers. The neighbors come from
// two single-port line buffers (one read and one write per pixel), and the
// lightmap is one single-port memory that serves loads and lookups in order. An
// eight-entry output queue absorbs stalls; the input stays ready while it holds
// four entries or fewer. The lightmap has no reset: read only entries that were
// loaded. The user writes registers only while the block is idle (not enforced).
module bump_map_light_shader (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [bmls_pkg::CFG_W-1:0] i_cfg_data,
    bmls_in_if.sink                         i_in,
    bmls_out_if.source                      o_out
);

    // configuration registers
    bmls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_x <= '0;
            r_cfg.light_y <= '0;
            r_cfg.x_bias  <= bmls_pkg::BIAS_W'(96);
            r_cfg.y_bias  <= bmls_pkg::BIAS_W'(156);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmls_pkg::CFG_LIGHT_X: r_cfg.light_x <= i_cfg_data;
                bmls_pkg::CFG_LIGHT_Y: r_cfg.light_y <= i_cfg_data;
                bmls_pkg::CFG_X_BIAS:  r_cfg.x_bias  <= i_cfg_data[bmls_pkg::BIAS_W-1:0];
                bmls_pkg::CFG_Y_BIAS:  r_cfg.y_bias  <= i_cfg_data[bmls_pkg::BIAS_W-1:0];
                default:               r_cfg         <= r_cfg;
            endcase
        end
    end

    // input handshake
    logic space;
    logic acc;

    assign i_in.ready = space;
    assign acc        = i_in.valid && space;

    bmls_pkg::t_tap tap;
    bmls_pkg::t_res res;

    bmls_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_mode        (i_in.mode),
        .i_light_addr  (i_in.light_addr),
        .i_light_value (i_in.light_value),
        .i_height      (i_in.height),
        .o_tap         (tap)
    );

    bmls_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_tap   (tap),
        .o_res   (res)
    );

    bmls_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ test/bmls_shade_checker.sv @@
`timescale 1ns / 1ps

module bmls_shade_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [bmls_pkg::CFG_W-1:0] i_cfg_data,
    bmls_in_if                              i_in,
    bmls_out_if                             i_out,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_shades_checked,
    output int                              o_frames_done
);

    localparam int WIDTH       = bmls_pkg::WIDTH;
    localparam int LM_AW       = bmls_pkg::LM_AW;
    localparam int CFG_W       = bmls_pkg::CFG_W;
    localparam int BIAS_W      = bmls_pkg::BIAS_W;
    localparam int WIN_LEN     = 2 * WIDTH + 1;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [7:0] shade;
        logic       last;
    } t_shade;

    // predictor state: pixel delay line, lightmap copy, raster position, registers
    logic [7:0]              height_line [WIN_LEN];
    logic [7:0]              light_mem   [1 << LM_AW];
    int                      col_pos;
    int                      row_pos;
    logic signed [CFG_W-1:0] light_x;
    logic signed [CFG_W-1:0] light_y;
    logic [BIAS_W-1:0]       x_bias;
    logic [BIAS_W-1:0]       y_bias;

    t_shade                  shade_q [$];
    int                      fails;
    int                      checked;
    int                      frames;

    function automatic void note_mismatch(string field, logic [7:0] want_v, logic [7:0] got_v);
        fails++;
        if (fails <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
        end
        if (fails == MAX_REPORTS) begin
            $display("%0t: further mismatches are counted but not shown", $time);
        end
    endfunction

    always @(posedge i_clk) begin
        t_shade            want;
        logic signed [7:0] gx;
        logic signed [7:0] gy;
        int                dx;
        int                dy;
        logic [LM_AW-1:0]  idx;

        if (!i_rst_n) begin
            for (int k = 0; k < WIN_LEN; k++) height_line[k] = 8'd0;
            col_pos = 0;
            row_pos = 0;
            light_x = '0;
            light_y = '0;
            x_bias  = BIAS_W'(96);
            y_bias  = BIAS_W'(156);
            shade_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bmls_pkg::CFG_LIGHT_X: light_x = i_cfg_data;
                    bmls_pkg::CFG_LIGHT_Y: light_y = i_cfg_data;
                    bmls_pkg::CFG_X_BIAS:  x_bias  = i_cfg_data[BIAS_W-1:0];
                    bmls_pkg::CFG_Y_BIAS:  y_bias  = i_cfg_data[BIAS_W-1:0];
                    default: ;
                endcase
            end

            // accepted request: lightmap load or height pixel
            if (i_in.valid && i_in.ready) begin
                if (!i_in.mode) begin
                    light_mem[LM_AW'(i_in.light_addr)] = i_in.light_value;
                end else begin
                    for (int k = WIN_LEN - 1; k > 0; k--) height_line[k] = height_line[k-1];
                    height_line[0] = i_in.height;

                    // centre pixel exists once two rows are in the line
                    if (row_pos >= 2) begin
                        gx = height_line[WIDTH-1] - height_line[WIDTH+1];
                        gy = height_line[0] - height_line[2*WIDTH];
                        dx = int'(gx) - int'(light_x) + int'(x_bias) + col_pos;
                        dy = int'(gy) - int'(light_y) + int'(y_bias) + (row_pos - 1);
                        idx = LM_AW'((dy << bmls_pkg::LIGHT_BITS) + dx);
                        want.shade = light_mem[idx];
                        want.last  = (row_pos == bmls_pkg::OUT_ROWS + 1) &&
                                     (col_pos == WIDTH - 1);
                        shade_q.push_back(want);
                    end

                    // raster position, wraps at frame end
                    col_pos++;
                    if (col_pos >= WIDTH) begin
                        col_pos = 0;
                        row_pos++;
                        if (row_pos >= bmls_pkg::OUT_ROWS + 2) row_pos = 0;
                    end
                end
            end

            // accepted shade against the oldest expectation
            if (i_out.valid && i_out.ready) begin
                if (shade_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("%0t: shade mismatch: expected none, actual shade %0d last %0d",
                                 $time, i_out.shade, i_out.last);
                    end
                end else begin
                    want = shade_q.pop_front();
                    if (i_out.shade !== want.shade) begin
                        note_mismatch("shade", want.shade, i_out.shade);
                    end
                    if (i_out.last !== want.last) begin
                        note_mismatch("last", {7'd0, want.last}, {7'd0, i_out.last});
                    end
                    checked++;
                    if (want.last) frames++;
                end
            end
        end

        o_fail_count     <= fails;
        o_pending        <= shade_q.size();
        o_shades_checked <= checked;
        o_frames_done    <= frames;
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int WIDTH        = bmls_pkg::WIDTH;
    localparam int CFG_W        = bmls_pkg::CFG_W;
    localparam int BIAS_W       = bmls_pkg::BIAS_W;
    localparam int ADDR_W       = bmls_pkg::ADDR_W;
    localparam int CYCLE_LIMIT  = 100_000;
    localparam int DRAIN_CYCLES = 4 * bmls_pkg::PIPE_LAT + bmls_pkg::FIFO_DEPTH;
    localparam int HOLD_CYCLES  = 300;
    localparam int FILL_PIXELS  = 2 * WIDTH;
    localparam int PHASES       = 5;
    localparam int PHASE_PIXELS = 64;
    localparam int MAX_PIXELS   = FILL_PIXELS + PHASES * PHASE_PIXELS;
    localparam int STORE_LEN    = 1 << bmls_pkg::LM_AW;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    bmls_in_if  req_ch ();
    bmls_out_if shade_ch ();

    int fail_count;
    int pending;
    int shades_checked;
    int frames_done;

    int cycles;
    int tx_idle_pct = 36;
    int rx_idle_pct = 36;
    int holds_asked;
    int loads_sent;
    int pixels_sent;
    bit light_loaded [STORE_LEN];

    // heights sent so far and the register values in force
    logic [7:0]              hist [MAX_PIXELS];
    logic signed [CFG_W-1:0] cur_lx = '0;
    logic signed [CFG_W-1:0] cur_ly = '0;
    logic [BIAS_W-1:0]       cur_xb = BIAS_W'(96);
    logic [BIAS_W-1:0]       cur_yb = BIAS_W'(156);

    bump_map_light_shader uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch),
        .o_out      (shade_ch)
    );

    bmls_shade_checker u_shade_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in             (req_ch),
        .i_out            (shade_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_shades_checked (shades_checked),
        .o_frames_done    (frames_done)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d shades outstanding",
                     $time, cycles, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // shade receiver: random stalls, or one long hold-off when asked
    initial begin : shade_sink
        int holds_done;
        holds_done = 0;
        shade_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                shade_ch.ready <= 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                shade_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // one request with random idle cycles ahead of it
    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] addr,
                                input logic [7:0] value, input logic [7:0] height);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.light_addr  <= addr;
        req_ch.light_value <= value;
        req_ch.height      <= height;
        do @(posedge i_clk); while (!req_ch.ready);
        if (mode) begin
            pixels_sent++;
        end else begin
            loads_sent++;
            light_loaded[bmls_pkg::LM_AW'(addr)] = 1'b1;
        end
    endtask

    // one pixel; the lightmap entry it reads is loaded just ahead if still empty
    task automatic send_pixel(input logic [7:0] h);
        int                col;
        int                row;
        logic signed [7:0] gx;
        logic signed [7:0] gy;
        int                dx;
        int                dy;
        int                a;

        col = pixels_sent % WIDTH;
        row = (pixels_sent / WIDTH) % (bmls_pkg::OUT_ROWS + 2);
        hist[pixels_sent] = h;
        if (row >= 2) begin
            gx = hist[pixels_sent - (WIDTH - 1)] - hist[pixels_sent - (WIDTH + 1)];
            gy = h - hist[pixels_sent - 2 * WIDTH];
            dx = int'(gx) - int'(cur_lx) + int'(cur_xb) + col;
            dy = int'(gy) - int'(cur_ly) + int'(cur_yb) + (row - 1);
            a  = ((dy << bmls_pkg::LIGHT_BITS) + dx) & (STORE_LEN - 1);
            if (!light_loaded[a]) begin
                send_request(1'b0, ADDR_W'(a), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
            end
        end
        send_request(1'b1, ADDR_W'($urandom_range(STORE_LEN - 1)),
                     8'($urandom_range(255)), h);
    endtask

    // stop sending until every shade is back and the pipe has settled
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_light(input logic signed [CFG_W-1:0] lx, input logic signed [CFG_W-1:0] ly,
                             input logic [BIAS_W-1:0] xb, input logic [BIAS_W-1:0] yb);
        write_reg(bmls_pkg::CFG_LIGHT_X, lx);
        write_reg(bmls_pkg::CFG_LIGHT_Y, ly);
        write_reg(bmls_pkg::CFG_X_BIAS, CFG_W'(xb));
        write_reg(bmls_pkg::CFG_Y_BIAS, CFG_W'(yb));
        cfg_we <= 1'b0;
        cur_lx = lx;
        cur_ly = ly;
        cur_xb = xb;
        cur_yb = yb;
    endtask

    initial begin : stimulus
        logic [7:0] h;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= bmls_pkg::CFG_LIGHT_X;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= 1'b0;
        req_ch.light_addr  <= '0;
        req_ch.light_value <= 8'd0;
        req_ch.height      <= 8'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: address and value extremes, height extremes in the first row
        send_request(1'b0, 18'h00000, 8'h00, 8'hFF);
        send_request(1'b0, 18'h3FFFF, 8'hFF, 8'h00);
        send_request(1'b0, 18'h2AAAA, 8'hAA, 8'h55);
        send_request(1'b0, 18'h15555, 8'h55, 8'hAA);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);

        // first two rows only fill the line buffers
        while (pixels_sent < FILL_PIXELS) begin
            h = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                         : 8'($urandom_range(255));
            send_pixel(h);
        end

        // shaded pixels with stray loads, one register setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: ;
                1: set_light(-10'sd512, -10'sd512, 9'd0, 9'd0);
                2: set_light(10'sd511, 10'sd511, 9'd511, 9'd511);
                3: set_light(10'sd511, -10'sd512, 9'd0, 9'd511);
                default: set_light(CFG_W'($urandom_range(1023)), CFG_W'($urandom_range(1023)),
                                   BIAS_W'($urandom_range(511)), BIAS_W'($urandom_range(511)));
            endcase

            // one phase runs with no idling on either side
            tx_idle_pct = (ph == 2) ? 0 : 36;
            rx_idle_pct = (ph == 2) ? 0 : 36;

            for (int p = 0; p < PHASE_PIXELS; p++) begin
                if (ph == 3 && p == 8) begin
                    holds_asked++;
                end
                if ($urandom_range(9) == 0) begin
                    send_request(1'b0, ADDR_W'($urandom_range(STORE_LEN - 1)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                // edge heights now and then for large gradients
                if ($urandom_range(7) == 0) begin
                    h = $urandom_range(1) ? 8'hFF : 8'h00;
                end else begin
                    h = 8'($urandom_range(255));
                end
                send_pixel(h);
            end
        end

        wait_idle();

        $display("ran %0d pixels and %0d lightmap loads over %0d register settings",
                 pixels_sent, loads_sent, PHASES);
        $display("checked %0d shades (%0d frame ends), with one long receiver hold-off",
                 shades_checked, frames_done);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
